FILE: hdl/rmq_pkg.sv
package rmq_pkg;

   localparam int DATA_WIDTH_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 14;
   localparam int QUEUE_DEPTH       = 4;

   // quaternion component order on the result side
   typedef enum logic [1:0] {
      SLOT_X,
      SLOT_Y,
      SLOT_Z,
      SLOT_W
   } slot_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // width of the clamped square-root argument, unsigned
   function automatic int arg_width(input int dw, input int fb);
      int wide;
      wide = (dw > fb + 1) ? dw : fb + 1;
      return wide + 2;
   endfunction

   // width of one queued item: root slot, argument, three signed terms
   function automatic int item_width(input int dw, input int fb);
      return 2 + arg_width(dw, fb) + 3 * (dw + 1);
   endfunction

endpackage

FILE: hdl/rmq_front.sv
module rmq_front import rmq_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF,
   parameter int FB = FRACTION_BITS_DEF
) (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [DW-1:0]                req_row0_col0,
   input  logic signed [DW-1:0]                req_row0_col1,
   input  logic signed [DW-1:0]                req_row0_col2,
   input  logic signed [DW-1:0]                req_row1_col0,
   input  logic signed [DW-1:0]                req_row1_col1,
   input  logic signed [DW-1:0]                req_row1_col2,
   input  logic signed [DW-1:0]                req_row2_col0,
   input  logic signed [DW-1:0]                req_row2_col1,
   input  logic signed [DW-1:0]                req_row2_col2,
   input  qstat_type                           q_stat,
   output logic                                q_push,
   output logic [item_width(DW, FB)-1:0]       q_item
);

   localparam int AW  = arg_width(DW, FB);
   localparam int EW  = AW + 1;
   localparam int DW1 = DW + 1;
   localparam logic signed [EW-1:0] ONE = EW'(1) << FB;

   logic signed [EW-1:0]  trace;
   logic signed [EW-1:0]  arg;
   logic [AW-1:0]         arg_clamped;
   logic signed [DW1-1:0] lane0, lane1, lane2;
   logic [1:0]            axis;
   slot_type              root;

   assign req_stall = q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   always_comb begin
      trace = EW'(req_row0_col0) + EW'(req_row1_col1) + EW'(req_row2_col2);
      axis  = 2'd0;
      if (req_row1_col1 > req_row0_col0) axis = 2'd1;
      if (req_row2_col2 > ((axis == 2'd1) ? req_row1_col1 : req_row0_col0)) axis = 2'd2;
      if (trace > 0) begin
         root  = SLOT_W;
         arg   = trace + ONE;
         lane0 = DW1'(req_row1_col2) - DW1'(req_row2_col1);
         lane1 = DW1'(req_row2_col0) - DW1'(req_row0_col2);
         lane2 = DW1'(req_row0_col1) - DW1'(req_row1_col0);
      end else begin
         // lanes hold the three unscaled terms in slot order, root slot skipped
         case (axis)
            2'd0: begin
               root  = SLOT_X;
               arg   = EW'(req_row0_col0) - EW'(req_row1_col1) - EW'(req_row2_col2) + ONE;
               lane0 = DW1'(req_row0_col1) + DW1'(req_row1_col0);
               lane1 = DW1'(req_row0_col2) + DW1'(req_row2_col0);
               lane2 = DW1'(req_row1_col2) - DW1'(req_row2_col1);
            end
            2'd1: begin
               root  = SLOT_Y;
               arg   = EW'(req_row1_col1) - EW'(req_row2_col2) - EW'(req_row0_col0) + ONE;
               lane0 = DW1'(req_row1_col0) + DW1'(req_row0_col1);
               lane1 = DW1'(req_row1_col2) + DW1'(req_row2_col1);
               lane2 = DW1'(req_row2_col0) - DW1'(req_row0_col2);
            end
            default: begin
               root  = SLOT_Z;
               arg   = EW'(req_row2_col2) - EW'(req_row0_col0) - EW'(req_row1_col1) + ONE;
               lane0 = DW1'(req_row2_col0) + DW1'(req_row0_col2);
               lane1 = DW1'(req_row2_col1) + DW1'(req_row1_col2);
               lane2 = DW1'(req_row0_col1) - DW1'(req_row1_col0);
            end
         endcase
      end
      arg_clamped = (arg < 0) ? '0 : arg[AW-1:0];
   end

   assign q_item = {root, arg_clamped, lane2, lane1, lane0};

endmodule

FILE: hdl/rmq_queue.sv
module rmq_queue import rmq_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output qstat_type        stat,
   output logic [WIDTH-1:0] head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign stat.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? PW'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (push && !do_pop) count_in = CW'(count_ff + 1'b1);
      if (!push && do_pop) count_in = CW'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH)) else $error("queue count overrun");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      PW'(wr_ff - rd_ff) == PW'(count_ff)) else $error("queue pointers out of step");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("queue push lost");

endmodule

FILE: hdl/rmq_back.sv
module rmq_back import rmq_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF,
   parameter int FB = FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qstat_type                     q_stat,
   input  logic [item_width(DW, FB)-1:0] q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DW-1:0]          rsp_quat_x,
   output logic signed [DW-1:0]          rsp_quat_y,
   output logic signed [DW-1:0]          rsp_quat_z,
   output logic signed [DW-1:0]          rsp_quat_w
);

   localparam int AW  = arg_width(DW, FB);
   localparam int XW0 = AW + FB;
   localparam int RW  = (XW0 + 1) / 2;
   localparam int XW  = 2 * RW;
   localparam int SW  = RW + 1;
   localparam int MW  = DW + 1;
   localparam int NW  = MW + FB;
   localparam logic [NW-1:0] MAX_POS = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic [NW-1:0] MAX_NEG = MAX_POS + 1'b1;

   function automatic logic [DW-1:0] sat(input logic neg, input logic [NW-1:0] mag);
      logic [DW-1:0] res;
      if (!neg) res = (mag > MAX_POS) ? {1'b0, {(DW-1){1'b1}}} : mag[DW-1:0];
      else      res = (mag > MAX_NEG) ? {1'b1, {(DW-1){1'b0}}} : DW'(~mag[DW-1:0] + 1'b1);
      return res;
   endfunction

   logic adv;
   logic rsp_valid_ff;
   logic [DW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;

   assign adv   = !(rsp_valid_ff && rsp_stall);
   assign q_pop = adv && !q_stat.empty;

   // square root: two radicand bits per stage
   logic                sv_ff    [RW+1];
   slot_type            sroot_ff [RW+1];
   logic [RW+1:0]       sr_ff    [RW+1];
   logic [RW-1:0]       sq_ff    [RW+1];
   logic [XW-1:0]       sx_ff    [RW+1];
   logic signed [DW:0]  sd_ff    [RW+1][3];

   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else if (adv) sv_ff[0] <= !q_stat.empty;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sroot_ff[0] <= slot_type'(q_item[3*MW+AW +: 2]);
         sr_ff[0]    <= '0;
         sq_ff[0]    <= '0;
         sx_ff[0]    <= XW'(q_item[3*MW +: AW]) << FB;
         sd_ff[0][0] <= q_item[0 +: MW];
         sd_ff[0][1] <= q_item[MW +: MW];
         sd_ff[0][2] <= q_item[2*MW +: MW];
      end
   end

   for (genvar s = 0; s < RW; s++) begin : g_sqrt
      logic [RW+1:0] r2, trial;
      logic          ge;
      assign r2    = {sr_ff[s][RW-1:0], sx_ff[s][XW-1 -: 2]};
      assign trial = {sq_ff[s], 2'b01};
      assign ge    = (r2 >= trial);

      always_ff @(posedge clock) begin
         if (reset) sv_ff[s+1] <= 1'b0;
         else if (adv) sv_ff[s+1] <= sv_ff[s];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sroot_ff[s+1] <= sroot_ff[s];
            sr_ff[s+1]    <= ge ? (r2 - trial) : r2;
            sq_ff[s+1]    <= {sq_ff[s][RW-2:0], ge};
            sx_ff[s+1]    <= sx_ff[s] << 2;
            sd_ff[s+1]    <= sd_ff[s];
         end
      end
   end

   // restoring division, one quotient bit per stage, three lanes
   logic           dv_ff    [NW+1];
   slot_type       droot_ff [NW+1];
   logic [RW-1:0]  ds_ff    [NW+1];
   logic           dneg_ff  [NW+1][3];
   logic [SW-1:0]  dr_ff    [NW+1][3];
   logic [NW-1:0]  dn_ff    [NW+1][3];
   logic [NW-1:0]  dq_ff    [NW+1][3];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (adv) dv_ff[0] <= sv_ff[RW];
   end

   for (genvar l = 0; l < 3; l++) begin : g_setup
      logic          neg;
      logic [MW-1:0] mag;
      assign neg = sd_ff[RW][l][DW];
      assign mag = neg ? MW'(~sd_ff[RW][l] + 1'b1) : sd_ff[RW][l];

      always_ff @(posedge clock) begin
         if (adv) begin
            dneg_ff[0][l] <= neg;
            dr_ff[0][l]   <= '0;
            dq_ff[0][l]   <= '0;
            // round to nearest: add half the divisor
            dn_ff[0][l]   <= (NW'(mag) << (FB - 1)) + NW'(sq_ff[RW] >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         droot_ff[0] <= sroot_ff[RW];
         ds_ff[0]    <= sq_ff[RW];
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else if (adv) dv_ff[k+1] <= dv_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            droot_ff[k+1] <= droot_ff[k];
            ds_ff[k+1]    <= ds_ff[k];
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [SW-1:0] r2;
         logic          ge;
         assign r2 = {dr_ff[k][l][SW-2:0], dn_ff[k][l][NW-1]};
         assign ge = (r2 >= {1'b0, ds_ff[k]});

         always_ff @(posedge clock) begin
            if (adv) begin
               dneg_ff[k+1][l] <= dneg_ff[k][l];
               dr_ff[k+1][l]   <= ge ? SW'(r2 - {1'b0, ds_ff[k]}) : r2;
               dn_ff[k+1][l]   <= dn_ff[k][l] << 1;
               dq_ff[k+1][l]   <= {dq_ff[k][l][NW-2:0], ge};
            end
         end
      end
   end

   // output assembly and saturation
   logic [DW-1:0] lane_val [3];
   logic [DW-1:0] half_val;
   logic          s_zero;
   slot_type      root;

   assign s_zero   = (ds_ff[NW] == '0);
   assign root     = droot_ff[NW];
   assign half_val = sat(1'b0, NW'(ds_ff[NW] >> 1));

   for (genvar l = 0; l < 3; l++) begin : g_sat
      assign lane_val[l] = s_zero ? '0 : sat(dneg_ff[NW][l], dq_ff[NW][l]);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_ff[NW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff <= (root == SLOT_X) ? half_val : lane_val[0];
         qy_ff <= (root == SLOT_Y) ? half_val :
                  (root == SLOT_X) ? lane_val[0] : lane_val[1];
         qz_ff <= (root == SLOT_Z) ? half_val :
                  (root == SLOT_W) ? lane_val[2] : lane_val[1];
         qw_ff <= (root == SLOT_W) ? half_val : lane_val[2];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;

   a_rem_lane0: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[NW] && !s_zero) |-> dr_ff[NW][0] < {1'b0, ds_ff[NW]})
      else $error("divider remainder out of range");

   a_rem_lane2: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[NW] && !s_zero) |-> dr_ff[NW][2] < {1'b0, ds_ff[NW]})
      else $error("divider remainder out of range");

   a_rise_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(dv_ff[NW]))
      else $error("result raised without an item in flight");

endmodule

FILE: hdl/rotation_matrix_to_quaternion.sv
// From input transfer to result valid: queue, root input register, RW root stages,
//   divider setup register, NW divide stages, output register, with RW = (AW +
//   FRACTION_BITS + 1) / 2 and NW = DATA_WIDTH + 1 + FRACTION_BITS; default Q2.14.
// Throughput: one matrix per cycle unless stalled; root/divide units fully pipelined.
// Reset (synchronous, active high) empties the queue and clears all stage valids.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
   parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_row0_col0,
   input  logic signed [DATA_WIDTH-1:0] req_row0_col1,
   input  logic signed [DATA_WIDTH-1:0] req_row0_col2,
   input  logic signed [DATA_WIDTH-1:0] req_row1_col0,
   input  logic signed [DATA_WIDTH-1:0] req_row1_col1,
   input  logic signed [DATA_WIDTH-1:0] req_row1_col2,
   input  logic signed [DATA_WIDTH-1:0] req_row2_col0,
   input  logic signed [DATA_WIDTH-1:0] req_row2_col1,
   input  logic signed [DATA_WIDTH-1:0] req_row2_col2,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_z,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w
);

   localparam int IW = item_width(DATA_WIDTH, FRACTION_BITS);

   // Front end: per transfer, picks the branch (positive trace or largest
   // diagonal), forms the clamped root argument and the three off-diagonal
   // sums/differences, ordered by destination slot.
   qstat_type         q_stat;
   logic              q_push, q_pop;
   logic [IW-1:0]     q_in, q_head;

   rmq_front #(.DW(DATA_WIDTH), .FB(FRACTION_BITS)) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row0_col0 (req_row0_col0),
      .req_row0_col1 (req_row0_col1),
      .req_row0_col2 (req_row0_col2),
      .req_row1_col0 (req_row1_col0),
      .req_row1_col1 (req_row1_col1),
      .req_row1_col2 (req_row1_col2),
      .req_row2_col0 (req_row2_col0),
      .req_row2_col1 (req_row2_col1),
      .req_row2_col2 (req_row2_col2),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_item        (q_in)
   );

   // Short queue decouples input stall from the back-end pipeline stall.
   rmq_queue #(.WIDTH(IW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .stat      (q_stat),
      .head      (q_head)
   );

   // Back end: pipelined integer square root gives S, its half is the root
   // component; three pipelined dividers scale the terms by 0.5/S with
   // round-to-nearest, then everything saturates into the output register.
   // The whole pipe holds while a finished result is stalled.
   rmq_back #(.DW(DATA_WIDTH), .FB(FRACTION_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_item     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_quat_x (rsp_quat_x),
      .rsp_quat_y (rsp_quat_y),
      .rsp_quat_z (rsp_quat_z),
      .rsp_quat_w (rsp_quat_w)
   );

endmodule

FILE: tb/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
   import rmq_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRACTION_BITS_DEF;
   localparam int LATENCY = 50;
   localparam int N_RANDOM = 1750;

   typedef logic signed [DW-1:0] sample_t;
   typedef sample_t matrix_t[3][3];

   typedef struct {
      sample_t q[4];   // indexed by slot_type
   } quat_t;

   // Fixed-point Shoemake conversion, computed independently of the RTL
   class quat_scoreboard;
      quat_t expected_q[$];
      int    mismatches;
      int    checked;

      function automatic longint unsigned root(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function automatic sample_t clip(longint v);
         longint hi;
         hi = (64'sd1 <<< (DW - 1)) - 1;
         if (v > hi) return sample_t'(hi);
         if (v < -hi - 1) return sample_t'(-hi - 1);
         return sample_t'(v);
      endfunction

      // d * 0.5 / s, rounded half away from zero; zero reciprocal when s is zero
      function automatic longint half_over_s(longint d, longint unsigned s);
         longint unsigned mag;
         longint unsigned quo;
         if (s == 0) return 0;
         mag = (d < 0) ? longint'(-d) : longint'(d);
         mag <<= (FB - 1);
         quo = (mag + (s >> 1)) / s;
         return (d < 0) ? -longint'(quo) : longint'(quo);
      endfunction

      function void note_matrix(matrix_t m);
         longint e[3][3];
         longint q[4];
         longint tr;
         longint a;
         longint unsigned s;
         int i;
         int j;
         int k;
         quat_t r;
         for (int rr = 0; rr < 3; rr++)
            for (int cc = 0; cc < 3; cc++)
               e[rr][cc] = longint'(m[rr][cc]);
         tr = e[0][0] + e[1][1] + e[2][2];
         if (tr > 0) begin
            a = tr + (64'sd1 <<< FB);
            s = root(longint'(a) << FB);
            q[SLOT_W] = longint'(root(longint'(a) << (FB - 2)));
            q[SLOT_X] = half_over_s(e[1][2] - e[2][1], s);
            q[SLOT_Y] = half_over_s(e[2][0] - e[0][2], s);
            q[SLOT_Z] = half_over_s(e[0][1] - e[1][0], s);
         end else begin
            i = 0;
            if (e[1][1] > e[0][0]) i = 1;
            if (e[2][2] > e[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            a = e[i][i] - (e[j][j] + e[k][k]) + (64'sd1 <<< FB);
            if (a < 0) a = 0;
            s = root(longint'(a) << FB);
            q[i] = longint'(root(longint'(a) << (FB - 2)));
            q[SLOT_W] = half_over_s(e[j][k] - e[k][j], s);
            q[j] = half_over_s(e[i][j] + e[j][i], s);
            q[k] = half_over_s(e[i][k] + e[k][i], s);
         end
         for (int n = 0; n < 4; n++) r.q[n] = clip(q[n]);
         expected_q.push_back(r);
      endfunction

      function void check_quat(quat_t got);
         quat_t want;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result transfer");
            return;
         end
         want = expected_q.pop_front();
         for (int n = 0; n < 4; n++)
            if (want.q[n] !== got.q[n]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result %0d slot %0d: expected %0d got %0d",
                     checked, n, want.q[n], got.q[n]);
            end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   sample_t req_m[3][3];
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   sample_t rsp_quat_x;
   sample_t rsp_quat_y;
   sample_t rsp_quat_z;
   sample_t rsp_quat_w;

   // idle/stall pressure in percent, changed per phase
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sent = 0;
   int n_pos_trace = 0;
   int n_diag_axis[3] = '{0, 0, 0};

   quat_scoreboard quat_sb = new();

   always #10 clock = ~clock;

   initial begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            req_m[r][c] = '0;
   end

   rotation_matrix_to_quaternion i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row0_col0 (req_m[0][0]),
      .req_row0_col1 (req_m[0][1]),
      .req_row0_col2 (req_m[0][2]),
      .req_row1_col0 (req_m[1][0]),
      .req_row1_col1 (req_m[1][1]),
      .req_row1_col2 (req_m[1][2]),
      .req_row2_col0 (req_m[2][0]),
      .req_row2_col1 (req_m[2][1]),
      .req_row2_col2 (req_m[2][2]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_quat_x    (rsp_quat_x),
      .rsp_quat_y    (rsp_quat_y),
      .rsp_quat_z    (rsp_quat_z),
      .rsp_quat_w    (rsp_quat_w)
   );

   // Result side: random stall, check each accepted transfer at the edge
   always @(posedge clock) begin
      quat_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.q[SLOT_X] = rsp_quat_x;
         got.q[SLOT_Y] = rsp_quat_y;
         got.q[SLOT_Z] = rsp_quat_z;
         got.q[SLOT_W] = rsp_quat_w;
         quat_sb.check_quat(got);
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // One matrix transfer; random idle cycles before it, valid held until accepted
   task automatic send_matrix(matrix_t m);
      longint tr;
      int i;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            req_m[r][c] <= m[r][c];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      quat_sb.note_matrix(m);
      sent++;
      tr = longint'(m[0][0]) + m[1][1] + m[2][2];
      if (tr > 0) n_pos_trace++;
      else begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         n_diag_axis[i]++;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (quat_sb.expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic sample_t rand_sample();
      return sample_t'($urandom());
   endfunction

   // Rotation matrix about one axis with random cos/sin-like entries,
   // plus a small perturbation; lands in all branches depending on angle
   function automatic matrix_t rand_rotation();
      matrix_t m;
      int ax;
      int cs;
      int sn;
      ax = $urandom_range(2);
      cs = int'($urandom_range(32768)) - 16384;
      sn = int'($urandom_range(32768)) - 16384;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m[r][c] = sample_t'(int'($urandom_range(64)) - 32);
      m[ax][ax] = sample_t'(16384 - int'($urandom_range(64)));
      m[(ax + 1) % 3][(ax + 1) % 3] = sample_t'(cs);
      m[(ax + 2) % 3][(ax + 2) % 3] = sample_t'(cs);
      m[(ax + 1) % 3][(ax + 2) % 3] = sample_t'(-sn);
      m[(ax + 2) % 3][(ax + 1) % 3] = sample_t'(sn);
      if ($urandom_range(1)) m[ax][ax] = -m[ax][ax];
      return m;
   endfunction

   function automatic matrix_t rand_matrix();
      matrix_t m;
      int kind;
      kind = $urandom_range(9);
      if (kind < 6) return rand_rotation();
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            if (kind < 9) m[r][c] = rand_sample();
            else m[r][c] = sample_t'(
               ($urandom_range(1)) ? 16'sh7fff - $urandom_range(3) : 16'sh8000 + $urandom_range(3));
      return m;
   endfunction

   function automatic matrix_t diag(int a, int b, int c, int off);
      matrix_t m;
      for (int r = 0; r < 3; r++)
         for (int cc = 0; cc < 3; cc++)
            m[r][cc] = sample_t'(off * (r * 3 + cc + 1));
      m[0][0] = sample_t'(a);
      m[1][1] = sample_t'(b);
      m[2][2] = sample_t'(c);
      return m;
   endfunction

   initial begin
      matrix_t m;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, each pi rotation, ties in the diagonal,
      // all-negative diagonals, saturation, full-scale entries
      send_matrix(diag(16384, 16384, 16384, 0));
      send_matrix(diag(16384, -16384, -16384, 0));
      send_matrix(diag(-16384, 16384, -16384, 0));
      send_matrix(diag(-16384, -16384, 16384, 0));
      send_matrix(diag(0, 0, 0, 100));
      send_matrix(diag(-5000, -5000, -5000, 300));
      send_matrix(diag(-16384, -16384, -16384, 500));
      send_matrix(diag(-32768, 32767, 32767, 700));
      send_matrix(diag(-32768, -32768, -32768, 0));
      send_matrix(diag(-32768, -32768, -32768, 4000));
      send_matrix(diag(32767, 32767, 32767, -4000));
      send_matrix(diag(1, 0, 0, 32767));
      send_matrix(diag(-1, 0, 0, -3000));
      send_matrix(diag(-20000, 32767, -32768, 0));
      send_matrix(diag(0, -1, -1, 9000));
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m[r][c] = (r == c) ? 16'sh8000 : ((r < c) ? 16'sh7fff : 16'sh8000);
      send_matrix(m);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m[r][c] = (r == c) ? -16'sd20000 : ((r < c) ? 16'sh8000 : 16'sh7fff);
      send_matrix(m);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m[r][c] = 16'shffff;
      send_matrix(m);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m[r][c] = 16'sh5555 ^ {16{(r + c) % 2 == 1}};
      send_matrix(m);
      // hold off until the pipeline is empty
      drain_results();

      // Random phases: no idling, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 11 : 66) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 11 : 66) : 0;
         for (int n = 0; n < N_RANDOM / 4; n++) send_matrix(rand_matrix());
         if (ph == 1) drain_results();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (quat_sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Converted %0d matrices: %0d with positive trace, %0d/%0d/%0d by x/y/z diagonal.",
         sent, n_pos_trace, n_diag_axis[0], n_diag_axis[1], n_diag_axis[2]);
      $display("Checked %0d quaternions, %0d field mismatches.", quat_sb.checked,
         quat_sb.mismatches);
      if (quat_sb.mismatches == 0 && quat_sb.expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #20ms;
      $display("ERROR: timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
